FILE: rtl/core/sfs_pkg.sv
package sfs_pkg;

  // Default sizing of the top level
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_TIME_BITS   = 21;

  // Field and internal widths
  localparam int DIM_W      = 11;  // frame width / height
  localparam int COL_W      = 7;   // sheet columns / rows
  localparam int PER_W      = 20;  // frame period
  localparam int FIRST_W    = 12;  // range first
  localparam int LIMIT_W    = 13;  // range limit
  localparam int MODE_W     = 3;
  localparam int REQ_W      = 3;
  localparam int EL_W       = 20;
  localparam int POS_W      = 13;  // sequence position
  localparam int FRM_W      = 14;  // frame index, holds columns * rows
  localparam int HALF_W     = 15;  // one-way list length
  localparam int LEN_W      = 14;  // capped total length
  localparam int PIX_W      = 16;
  localparam int OUT_FRM_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int POS_CAP    = 8192;

  // play_mode bits
  localparam int MODE_LOOP = 0;
  localparam int MODE_PING = 1;
  localparam int MODE_BACK = 2;

  // Register values after reset
  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 11'd16;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 11'd16;
  localparam logic [COL_W-1:0]   RST_SHEET_COLS   = 7'd1;
  localparam logic [COL_W-1:0]   RST_SHEET_ROWS   = 7'd1;
  localparam logic [PER_W-1:0]   RST_FRAME_PERIOD = 20'd16667;
  localparam logic [FIRST_W-1:0] RST_RANGE_FIRST  = 12'd0;
  localparam logic [LIMIT_W-1:0] RST_RANGE_LIMIT  = 13'd1;
  localparam logic [MODE_W-1:0]  RST_PLAY_MODE    = 3'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_PAUSE  = 3'd3,
    REQ_RESUME = 3'd4
  } sfs_req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_SHEET_COLS   = 3'd2,
    CFG_SHEET_ROWS   = 3'd3,
    CFG_FRAME_PERIOD = 3'd4,
    CFG_RANGE_FIRST  = 3'd5,
    CFG_RANGE_LIMIT  = 3'd6,
    CFG_PLAY_MODE    = 3'd7
  } sfs_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_LEN,
    ST_ADV,
    ST_SEL,
    ST_FRAME,
    ST_KICK,
    ST_PIX,
    ST_DONE
  } sfs_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_MUL
  } sfs_phase_t;

  typedef struct packed {
    logic             start;
    logic [FRM_W-1:0] frame;
    logic [COL_W-1:0] cols;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } sfs_pix_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } sfs_pix_rsp_t;

endpackage

FILE: rtl/core/sfs_pixmap.sv
module sfs_pixmap
  import sfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  sfs_pix_req_t req,
  output sfs_pix_rsp_t rsp
);

  localparam int STEP_MAX = (FRM_W > COL_W) ? FRM_W : COL_W;
  localparam int CNT_W    = $clog2(STEP_MAX);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRM_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(COL_W - 1);

  sfs_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FRM_W-1:0] div_r, div_nxt;
  logic [COL_W-1:0] rem_r, rem_nxt;
  logic [PIX_W-1:0] px_r, px_nxt;
  logic [PIX_W-1:0] py_r, py_nxt;

  logic             load, div_step, mul_step, div_end, mul_end, done;
  logic [COL_W:0]   trial;
  logic             trial_ge;

  // Restoring divide: one dividend bit per cycle, MSB first
  assign trial    = {rem_r, div_r[FRM_W-1]};
  assign trial_ge = trial >= {1'b0, req.cols};
  assign div_end  = cnt_r == DIV_LAST;
  assign mul_end  = cnt_r == MUL_LAST;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (req.start) phase_nxt = PH_DIV;
      PH_DIV:  if (div_end) phase_nxt = PH_MUL;
      PH_MUL:  if (mul_end) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Phase outputs
  always_comb begin
    load     = 1'b0;
    div_step = 1'b0;
    mul_step = 1'b0;
    done     = 1'b0;
    case (phase_r)
      PH_IDLE: load = req.start;
      PH_DIV:  div_step = 1'b1;
      PH_MUL: begin
        mul_step = 1'b1;
        done     = mul_end;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    if (load) begin
      cnt_nxt = '0;
      div_nxt = req.frame;
      rem_nxt = '0;
      px_nxt  = '0;
      py_nxt  = '0;
    end else if (div_step) begin
      cnt_nxt = div_end ? '0 : cnt_r + 1'b1;
      div_nxt = {div_r[FRM_W-2:0], 1'b0};
      rem_nxt = trial_ge ? COL_W'(trial - {1'b0, req.cols}) : trial[COL_W-1:0];
      // Row times height, Horner form on each quotient bit
      py_nxt  = {py_r[PIX_W-2:0], 1'b0} + (trial_ge ? PIX_W'(req.height) : '0);
    end else if (mul_step) begin
      cnt_nxt = cnt_r + 1'b1;
      rem_nxt = {rem_r[COL_W-2:0], 1'b0};
      px_nxt  = {px_r[PIX_W-2:0], 1'b0} + (rem_r[COL_W-1] ? PIX_W'(req.width) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
  end

  assign rsp = {done, px_r, py_r};

endmodule

FILE: rtl/core/sprite_frame_sequencer_core.sv
// Sprite frame sequencer: plays a frame range on a sprite sheet grid.
// A request runs through the CMD, LEN, ADV, SEL, FRAME and KICK states; a frame
//   on the sheet then goes through the bit-serial divide and column multiply
//   of the pixel unit before DONE loads the output register. One request is
//   handled at a time; the next is taken once the word is in the output register.
// Reset (rst_n low, synchronous): registers take their defaults, playback stops.
module sprite_frame_sequencer_core
  import sfs_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [EL_W-1:0]       in_elapsed_ticks,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_FRM_W-1:0]  out_frame_number,
  output logic [PIX_W-1:0]      out_pixel_x,
  output logic [PIX_W-1:0]      out_pixel_y,
  output logic                  out_is_playing,
  output logic                  out_frame_valid,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Accumulator sum is wide enough for both the accumulator and the period.
  localparam int SUM_W = ((TIME_BITS > PER_W) ? TIME_BITS : PER_W) + 1;
  localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({TIME_BITS{1'b1}});

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]   cfg_width_r;
  logic [DIM_W-1:0]   cfg_height_r;
  logic [COL_W-1:0]   cfg_cols_r;
  logic [COL_W-1:0]   cfg_rows_r;
  logic [PER_W-1:0]   cfg_period_r;
  logic [FIRST_W-1:0] cfg_first_r;
  logic [LIMIT_W-1:0] cfg_limit_r;
  logic [MODE_W-1:0]  cfg_mode_r;

  // Writes must come only while the block is idle; the block does not enforce it and always takes them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_FRAME_WIDTH;
      cfg_height_r <= RST_FRAME_HEIGHT;
      cfg_cols_r   <= RST_SHEET_COLS;
      cfg_rows_r   <= RST_SHEET_ROWS;
      cfg_period_r <= RST_FRAME_PERIOD;
      cfg_first_r  <= RST_RANGE_FIRST;
      cfg_limit_r  <= RST_RANGE_LIMIT;
      cfg_mode_r   <= RST_PLAY_MODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_width_r  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_height_r <= cfg_data[DIM_W-1:0];
        CFG_SHEET_COLS:   cfg_cols_r   <= cfg_data[COL_W-1:0];
        CFG_SHEET_ROWS:   cfg_rows_r   <= cfg_data[COL_W-1:0];
        CFG_FRAME_PERIOD: cfg_period_r <= cfg_data[PER_W-1:0];
        CFG_RANGE_FIRST:  cfg_first_r  <= cfg_data[FIRST_W-1:0];
        CFG_RANGE_LIMIT:  cfg_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_PLAY_MODE:    cfg_mode_r   <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------
  sfs_state_t           state_r, state_nxt;

  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [EL_W-1:0]      el_r, el_nxt;
  logic [TIME_BITS-1:0] accum_r, accum_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 playing_r, playing_nxt;
  logic [FRM_W-1:0]     n_r, n_nxt;          // frames on the sheet
  logic [HALF_W-1:0]    f_r, f_nxt;          // one-way list length
  logic [LEN_W-1:0]     l_r, l_nxt;          // total length, capped
  logic [POS_W-1:0]     k_r, k_nxt;          // index into the one-way list
  logic                 len_ok_r, len_ok_nxt;
  logic [FRM_W-1:0]     fr_r, fr_nxt;
  logic                 fvalid_r, fvalid_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_FRM_W-1:0] out_frame_r, out_frame_nxt;
  logic [PIX_W-1:0]     out_px_r, out_px_nxt;
  logic [PIX_W-1:0]     out_py_r, out_py_nxt;
  logic                 out_play_r, out_play_nxt;
  logic                 out_fvalid_r, out_fvalid_nxt;

  // FSM outputs
  logic                 in_take, unit_start, out_load, out_free;

  // ---------------------------------------------------------------------
  // Per-state arithmetic
  // ---------------------------------------------------------------------
  logic [COL_W-1:0]     cols_eff, rows_eff;
  logic [LIMIT_W-1:0]   first_ext;
  logic [FRM_W-1:0]     first_frm;
  logic [SUM_W-1:0]     acc_sum, acc_sat, acc_w, per_w;
  logic                 period_hit;
  logic [HALF_W-1:0]    f_calc;
  logic [HALF_W:0]      l_ext;
  logic [LEN_W-1:0]     l_calc;
  logic [LEN_W-1:0]     pos_inc;
  logic [POS_W-1:0]     p_sel;
  logic [HALF_W:0]      k_mirror;
  logic [FRM_W-1:0]     a_calc, k_frm, fr_calc;

  // Clamp the grid to the supported size.
  assign cols_eff = (int'(cfg_cols_r) > MAX_COLUMNS) ? COL_W'(MAX_COLUMNS) : cfg_cols_r;
  assign rows_eff = (int'(cfg_rows_r) > MAX_ROWS) ? COL_W'(MAX_ROWS) : cfg_rows_r;

  assign first_ext = {1'b0, cfg_first_r};
  assign first_frm = FRM_W'(cfg_first_r);

  // Saturating accumulate, then test against the period.
  assign acc_sum    = SUM_W'(accum_r) + SUM_W'(el_r);
  assign acc_sat    = (acc_sum > ACC_MAX) ? ACC_MAX : acc_sum;
  assign acc_w      = SUM_W'(accum_r);
  assign per_w      = SUM_W'(cfg_period_r);
  assign period_hit = acc_w >= per_w;

  // One-way length: forward wraps past the last sheet frame when first > limit.
  always_comb begin
    if (first_ext == cfg_limit_r) begin
      f_calc = '0;
    end else if (cfg_mode_r[MODE_BACK]) begin
      f_calc = (cfg_limit_r > first_ext) ? HALF_W'(cfg_limit_r - first_ext) : '0;
    end else if (first_ext < cfg_limit_r) begin
      f_calc = HALF_W'(cfg_limit_r - first_ext);
    end else begin
      f_calc = ((n_r > first_frm) ? HALF_W'(n_r - first_frm) : '0) + HALF_W'(cfg_limit_r);
    end
  end

  // Ping-pong doubles the list; cap to the reach of the position counter.
  assign l_ext  = cfg_mode_r[MODE_PING] ? {f_r, 1'b0} : {1'b0, f_r};
  assign l_calc = (l_ext > (HALF_W+1)'(POS_CAP)) ? LEN_W'(POS_CAP) : l_ext[LEN_W-1:0];

  assign pos_inc = {1'b0, pos_r} + 1'b1;

  // Show the last position if the position ran past the list; mirror on return.
  assign p_sel    = ({1'b0, pos_r} < l_r) ? pos_r : POS_W'(l_r - 1'b1);
  assign k_mirror = {f_r, 1'b0} - 1'b1 - (HALF_W+1)'(p_sel);

  // Frame number of the one-way list element.
  assign a_calc = (n_r > first_frm) ? (n_r - first_frm) : '0;
  assign k_frm  = FRM_W'(k_r);
  always_comb begin
    if (cfg_mode_r[MODE_BACK]) begin
      fr_calc = FRM_W'(cfg_limit_r) - 1'b1 - k_frm;
    end else if (first_ext < cfg_limit_r) begin
      fr_calc = first_frm + k_frm;
    end else if (k_frm < a_calc) begin
      fr_calc = first_frm + k_frm;
    end else begin
      fr_calc = k_frm - a_calc;
    end
  end

  // ---------------------------------------------------------------------
  // Pixel unit: bit-serial column/row split and multiply
  // ---------------------------------------------------------------------
  sfs_pix_req_t pix_req;
  sfs_pix_rsp_t pix_rsp;

  assign pix_req.start  = unit_start;
  assign pix_req.frame  = fr_r;
  assign pix_req.cols   = cols_eff;
  assign pix_req.width  = cfg_width_r;
  assign pix_req.height = cfg_height_r;

  sfs_pixmap u_pixmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pix_req),
    .rsp   (pix_rsp)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CMD;
      ST_CMD:   state_nxt = ST_LEN;
      ST_LEN:   state_nxt = ST_ADV;
      ST_ADV:   state_nxt = ST_SEL;
      ST_SEL:   state_nxt = ST_FRAME;
      ST_FRAME: state_nxt = ST_KICK;
      ST_KICK:  state_nxt = fvalid_r ? ST_PIX : ST_DONE;
      ST_PIX:   if (pix_rsp.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall   = 1'b1;
    in_take    = 1'b0;
    unit_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_take  = in_valid;
      end
      ST_KICK: unit_start = fvalid_r;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------
  always_comb begin
    req_nxt     = req_r;
    el_nxt      = el_r;
    accum_nxt   = accum_r;
    pos_nxt     = pos_r;
    playing_nxt = playing_r;
    n_nxt       = n_r;
    f_nxt       = f_r;
    l_nxt       = l_r;
    k_nxt       = k_r;
    len_ok_nxt  = len_ok_r;
    fr_nxt      = fr_r;
    fvalid_nxt  = fvalid_r;

    case (state_r)
      ST_IDLE: begin
        // Capture the request word.
        if (in_take) begin
          req_nxt = in_req_type;
          el_nxt  = in_elapsed_ticks;
        end
      end
      ST_CMD: begin
        n_nxt = FRM_W'(cols_eff) * FRM_W'(rows_eff);
        case (req_r)
          REQ_TICK: begin
            // Ticks count only while playing.
            if (playing_r) accum_nxt = acc_sat[TIME_BITS-1:0];
          end
          REQ_START: begin
            playing_nxt = 1'b1;
            pos_nxt     = '0;
          end
          REQ_STOP: begin
            playing_nxt = 1'b0;
            pos_nxt     = '0;
          end
          REQ_PAUSE:  playing_nxt = 1'b0;
          REQ_RESUME: playing_nxt = 1'b1;
          default: ;  // unknown request: hold everything
        endcase
      end
      ST_LEN: begin
        f_nxt = f_calc;
      end
      ST_ADV: begin
        l_nxt = l_calc;
        // At most one step per tick; drop one period from the accumulator.
        if (req_r == REQ_TICK && playing_r && period_hit) begin
          accum_nxt = TIME_BITS'(acc_w - per_w);
          if (pos_inc >= l_calc) begin
            if (cfg_mode_r[MODE_LOOP]) begin
              pos_nxt = '0;
            end else begin
              // Hold the last frame and stop.
              pos_nxt     = (l_calc != '0) ? POS_W'(l_calc - 1'b1) : '0;
              playing_nxt = 1'b0;
            end
          end else begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end
      end
      ST_SEL: begin
        len_ok_nxt = l_r != '0;
        k_nxt      = (HALF_W'(p_sel) < f_r) ? p_sel : k_mirror[POS_W-1:0];
      end
      ST_FRAME: begin
        fr_nxt     = len_ok_r ? fr_calc : '0;
        fvalid_nxt = len_ok_r && (fr_calc < n_r);
      end
      default: ;
    endcase
  end

  // Output register: the next request may be taken while this word waits.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    out_px_nxt     = out_px_r;
    out_py_nxt     = out_py_r;
    out_play_nxt   = out_play_r;
    out_fvalid_nxt = out_fvalid_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_frame_nxt  = fr_r[OUT_FRM_W-1:0];
      out_px_nxt     = fvalid_r ? pix_rsp.x : '0;
      out_py_nxt     = fvalid_r ? pix_rsp.y : '0;
      out_play_nxt   = playing_r;
      out_fvalid_nxt = fvalid_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      accum_r     <= '0;
      pos_r       <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      pos_r       <= pos_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    el_r         <= el_nxt;
    n_r          <= n_nxt;
    f_r          <= f_nxt;
    l_r          <= l_nxt;
    k_r          <= k_nxt;
    len_ok_r     <= len_ok_nxt;
    fr_r         <= fr_nxt;
    fvalid_r     <= fvalid_nxt;
    out_frame_r  <= out_frame_nxt;
    out_px_r     <= out_px_nxt;
    out_py_r     <= out_py_nxt;
    out_play_r   <= out_play_nxt;
    out_fvalid_r <= out_fvalid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_frame_number = out_frame_r;
  assign out_pixel_x      = out_px_r;
  assign out_pixel_y      = out_py_r;
  assign out_is_playing   = out_play_r;
  assign out_frame_valid  = out_fvalid_r;

endmodule

FILE: rtl/core/sfs_checker.sv
module sfs_checker
  import sfs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [OUT_FRM_W-1:0] out_frame_number,
  input logic [PIX_W-1:0]     out_pixel_x,
  input logic [PIX_W-1:0]     out_pixel_y,
  input logic                 out_is_playing,
  input logic                 out_frame_valid
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};

  // Words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_pix_without_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |-> out_pixel_x == '0 && out_pixel_y == '0)
    else $error("pixel position set for an invalid frame");

  a_accept_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("request taken with two words pending");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result delivered without a pending request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_number) &&
      $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_is_playing) && $stable(out_frame_valid))
    else $error("stalled result changed");

endmodule

bind sprite_frame_sequencer_core sfs_checker u_sfs_checker (.*);
